### rtl/core/assert_macros.svh
// Shared assertion macros for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or expression checked at each rising edge outside reset.
`define DPB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dpb assertion failed");

// Condition that must never be true outside reset.
`define DPB_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("dpb forbidden condition seen");

`endif

### rtl/core/dpb_pkg.sv
`default_nettype none
package dpb_pkg;

  localparam int unsigned RegCount  = 6;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned QuotBits  = 32;
  localparam int unsigned DenWidth  = 36;
  localparam int unsigned ProdWidth = 37;

  typedef enum logic [2:0] {
    REG_DEPTH_SCALE = 3'd0,
    REG_FOCAL_X     = 3'd1,
    REG_FOCAL_Y     = 3'd2,
    REG_CENTER_X    = 3'd3,
    REG_CENTER_Y    = 3'd4,
    REG_MAX_DEPTH   = 3'd5
  } dpb_reg_e;

  typedef struct packed {
    logic [11:0] col;
    logic [11:0] row;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } dpb_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [31:0]        point_z;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
  } dpb_out_t;

  typedef struct packed {
    logic [15:0] depth_scale;
    logic [19:0] focal_x;
    logic [19:0] focal_y;
    logic [19:0] center_x;
    logic [19:0] center_y;
    logic [15:0] max_depth_code;
  } dpb_cfg_t;

  // One long-division lane: partial remainder, divisor, dividend bits still
  // to shift in, quotient bits so far.
  typedef struct packed {
    logic [DenWidth-1:0] rem;
    logic [DenWidth-1:0] den;
    logic [QuotBits-1:0] num_lo;
    logic [QuotBits-1:0] quot;
  } dpb_lane_t;

  typedef struct packed {
    logic      valid;
    logic      neg_x;
    logic      neg_y;
    logic      ovf_x;
    logic      ovf_y;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    dpb_lane_t lane_x;
    dpb_lane_t lane_y;
    dpb_lane_t lane_z;
  } dpb_stage_t;

endpackage
`default_nettype wire

### rtl/core/dpb_prep.sv
`default_nettype none
module dpb_prep import dpb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire logic       in_take_i,
  input  wire dpb_in_t    in_data_i,
  input  wire dpb_cfg_t   cfg_i,
  output dpb_stage_t      stage_o
);

  logic                 a_valid_q, a_valid_d;
  logic                 a_negx_q, a_negy_q;
  logic [ProdWidth-1:0] a_px_q, a_py_q, a_pz_q;
  logic [DenWidth-1:0]  a_denx_q, a_deny_q, a_denz_q;
  logic [23:0]          a_rgb_q;

  logic [15:0] scale;
  logic [19:0] fx, fy;
  logic [20:0] pcol, prow, magx, magy;
  logic        negx, negy, keep;

  always_comb begin
    scale = (cfg_i.depth_scale == '0) ? 16'd1 : cfg_i.depth_scale;
    fx    = (cfg_i.focal_x == '0) ? 20'd1 : cfg_i.focal_x;
    fy    = (cfg_i.focal_y == '0) ? 20'd1 : cfg_i.focal_y;
    pcol  = {1'b0, in_data_i.col, 8'd0};
    prow  = {1'b0, in_data_i.row, 8'd0};
    negx  = {1'b0, cfg_i.center_x} > pcol;
    negy  = {1'b0, cfg_i.center_y} > prow;
    magx  = negx ? ({1'b0, cfg_i.center_x} - pcol) : (pcol - {1'b0, cfg_i.center_x});
    magy  = negy ? ({1'b0, cfg_i.center_y} - prow) : (prow - {1'b0, cfg_i.center_y});
    // drop: no measurement, nearer than half a metre, beyond max code
    keep  = (in_data_i.depth != '0)
         && ({1'b0, in_data_i.depth, 1'b0} >= {2'b0, cfg_i.depth_scale})
         && (in_data_i.depth <= cfg_i.max_depth_code);
    a_valid_d = in_take_i && keep;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv_i) begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_negx_q <= negx;
      a_negy_q <= negy;
      a_px_q   <= ProdWidth'(magx * in_data_i.depth);
      a_py_q   <= ProdWidth'(magy * in_data_i.depth);
      a_pz_q   <= ProdWidth'(in_data_i.depth);
      a_denx_q <= DenWidth'(scale * fx);
      a_deny_q <= DenWidth'(scale * fy);
      a_denz_q <= DenWidth'(scale);
      a_rgb_q  <= {in_data_i.blue, in_data_i.green, in_data_i.red};
    end
  end

  // Dividend is product << 16; its top bits above the quotient width seed
  // the remainder, and a seed at or above the divisor means q >= 2^32.
  logic [20:0] hix, hiy, hiz;
  logic        ovx, ovy;
  dpb_stage_t  b_d, b_q;
  logic        b_valid_q;

  always_comb begin
    hix = a_px_q[ProdWidth-1:16];
    hiy = a_py_q[ProdWidth-1:16];
    hiz = a_pz_q[ProdWidth-1:16];
    ovx = {15'd0, hix} >= a_denx_q;
    ovy = {15'd0, hiy} >= a_deny_q;
    b_d = '0;
    b_d.valid  = a_valid_q;
    b_d.neg_x  = a_negx_q;
    b_d.neg_y  = a_negy_q;
    b_d.ovf_x  = ovx;
    b_d.ovf_y  = ovy;
    b_d.blue   = a_rgb_q[23:16];
    b_d.green  = a_rgb_q[15:8];
    b_d.red    = a_rgb_q[7:0];
    b_d.lane_x = '{rem: ovx ? '0 : {15'd0, hix}, den: a_denx_q,
                   num_lo: {a_px_q[15:0], 16'd0}, quot: '0};
    b_d.lane_y = '{rem: ovy ? '0 : {15'd0, hiy}, den: a_deny_q,
                   num_lo: {a_py_q[15:0], 16'd0}, quot: '0};
    b_d.lane_z = '{rem: {15'd0, hiz}, den: a_denz_q,
                   num_lo: {a_pz_q[15:0], 16'd0}, quot: '0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= b_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_q <= b_d;
    end
  end

  always_comb begin
    stage_o       = b_q;
    stage_o.valid = b_valid_q;
  end

endmodule
`default_nettype wire

### rtl/core/dpb_div_cell.sv
`default_nettype none
module dpb_div_cell import dpb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       adv_i,
  input  wire dpb_stage_t stage_i,
  output dpb_stage_t      stage_o
);

  function automatic dpb_lane_t div_step(dpb_lane_t l);
    logic [DenWidth:0] sh;
    logic              ge;
    dpb_lane_t         r;
    sh = {l.rem, l.num_lo[QuotBits-1]};
    ge = sh >= {1'b0, l.den};
    r.rem    = ge ? DenWidth'(sh - {1'b0, l.den}) : sh[DenWidth-1:0];
    r.den    = l.den;
    r.num_lo = {l.num_lo[QuotBits-2:0], 1'b0};
    r.quot   = {l.quot[QuotBits-2:0], ge};
    return r;
  endfunction

  dpb_stage_t nxt, data_q;
  logic       valid_q;

  always_comb begin
    nxt        = stage_i;
    nxt.lane_x = div_step(stage_i.lane_x);
    nxt.lane_y = div_step(stage_i.lane_y);
    nxt.lane_z = div_step(stage_i.lane_z);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= nxt;
    end
  end

  always_comb begin
    stage_o       = data_q;
    stage_o.valid = valid_q;
  end

endmodule
`default_nettype wire

### rtl/core/depth_pixel_back_projection.sv
`default_nettype none
// Channel   Direction  Payload     Handshake
// in        input      dpb_in_t    in_valid_i / in_stall_o
// out       output     dpb_out_t   out_valid_o / out_stall_i
// config    input      APB regs    psel/penable/pwrite/pready
//
// One pixel enters per cycle while not stalled; a result passes through
// two setup stages, a row of 32 restoring-division cells, one output stage.
// Throughput is set by the cell row: each cell retires one quotient bit of
// all three divisions per cycle, so a new pixel follows each unstalled cycle.
// Reset clears all valid flags and loads the register defaults.
// An output stall on a valid result freezes the whole row; in_stall_o follows it directly.
// Dropped pixels travel as bubbles and give no output transfer.
`include "assert_macros.svh"
module depth_pixel_back_projection import dpb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire dpb_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output dpb_out_t                  out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  dpb_cfg_t cfg_q;
  logic     adv;
  dpb_reg_e idx;

  assign pready = 1'b1;
  assign idx    = dpb_reg_e'(paddr[AddrWidth-1:2]);

  // Register file: write on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_scale    <= 16'd1000;
      cfg_q.focal_x        <= 20'd131072;
      cfg_q.focal_y        <= 20'd131072;
      cfg_q.center_x       <= 20'd81920;
      cfg_q.center_y       <= 20'd61440;
      cfg_q.max_depth_code <= 16'hFFFF;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_DEPTH_SCALE: cfg_q.depth_scale    <= pwdata[15:0];
        REG_FOCAL_X:     cfg_q.focal_x        <= pwdata[19:0];
        REG_FOCAL_Y:     cfg_q.focal_y        <= pwdata[19:0];
        REG_CENTER_X:    cfg_q.center_x       <= pwdata[19:0];
        REG_CENTER_Y:    cfg_q.center_y       <= pwdata[19:0];
        REG_MAX_DEPTH:   cfg_q.max_depth_code <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEPTH_SCALE: prdata = {16'd0, cfg_q.depth_scale};
      REG_FOCAL_X:     prdata = {12'd0, cfg_q.focal_x};
      REG_FOCAL_Y:     prdata = {12'd0, cfg_q.focal_y};
      REG_CENTER_X:    prdata = {12'd0, cfg_q.center_x};
      REG_CENTER_Y:    prdata = {12'd0, cfg_q.center_y};
      REG_MAX_DEPTH:   prdata = {16'd0, cfg_q.max_depth_code};
      default:         prdata = '0;
    endcase
  end

  // Advance the whole row unless a finished result is held by the sink.
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  dpb_stage_t chain [QuotBits+1];

  dpb_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_take_i (in_valid_i),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .stage_o   (chain[0])
  );

  for (genvar g = 0; g < QuotBits; g++) begin : g_cell
    dpb_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  // Saturate x and y to signed 32 bits and apply the sign.
  dpb_stage_t           last;
  logic [QuotBits-1:0]  qx, qy;
  dpb_out_t             res_d, out_q;
  logic                 out_valid_q;

  assign last = chain[QuotBits];

  always_comb begin
    if (last.neg_x) begin
      qx = (last.ovf_x || last.lane_x.quot > 32'h8000_0000) ? 32'h8000_0000
                                                            : last.lane_x.quot;
      qx = 32'(0 - qx);
    end else begin
      qx = (last.ovf_x || last.lane_x.quot > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                            : last.lane_x.quot;
    end
    if (last.neg_y) begin
      qy = (last.ovf_y || last.lane_y.quot > 32'h8000_0000) ? 32'h8000_0000
                                                            : last.lane_y.quot;
      qy = 32'(0 - qy);
    end else begin
      qy = (last.ovf_y || last.lane_y.quot > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                                            : last.lane_y.quot;
    end
    res_d.point_x   = qx;
    res_d.point_y   = qy;
    res_d.point_z   = last.lane_z.quot;
    res_d.out_blue  = last.blue;
    res_d.out_green = last.green;
    res_d.out_red   = last.red;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DPB_ASSERT(a_stall_link, clk_i, rst_ni, in_stall_o == (out_valid_o && out_stall_i))
  `DPB_NEVER(a_zero_depth, clk_i, rst_ni, out_valid_o && out_data_o.point_z == '0)
  `DPB_ASSERT(a_hold_last, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> $stable(last))
  `DPB_NEVER(a_not_ready, clk_i, rst_ni, !pready)

endmodule
`default_nettype wire

### tb/depth_pixel_back_projection_tb.sv
`default_nettype none
module depth_pixel_back_projection_tb import dpb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeLatency = 35;
  localparam int unsigned SettleCycles = PipeLatency + 8;
  localparam int unsigned CycleLimit = 2_000_000;
  // First index past the register file; writes there must be ignored.
  localparam int unsigned BadRegIdx = RegCount;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  dpb_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  dpb_out_t out_data_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  depth_pixel_back_projection dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow copy of the camera registers, kept in step with every APB write.
  dpb_cfg_t cam_cfg;
  // Points the block still owes us, oldest first.
  dpb_out_t pending_points[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run as failed once the cycle count passes CycleLimit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: a long hold-off takes priority, otherwise stall at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // One axis of the pinhole back-projection: exact single division,
  // truncated toward zero, then clamped to signed 32 bits.
  function automatic logic [31:0] project_axis(logic [11:0] pix, logic [19:0] ctr,
                                               logic [15:0] d, logic [15:0] s,
                                               logic [19:0] f);
    longint unsigned p;
    longint unsigned c;
    longint unsigned mag;
    longint unsigned quo;
    bit neg;
    p = longint'(pix) << 8;
    c = longint'(ctr);
    neg = c > p;
    mag = neg ? c - p : p - c;
    quo = (mag * longint'(d) * 64'd65536) / (longint'(s) * longint'(f));
    if (neg) begin
      if (quo > 64'h8000_0000) quo = 64'h8000_0000;
      return 32'(64'd0 - quo);
    end
    if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
    return quo[31:0];
  endfunction

  // Work out the point a pixel should give; drop it if it is out of range.
  function automatic void project_pixel(dpb_in_t px);
    dpb_out_t pt;
    logic [15:0] s;
    logic [19:0] fx;
    logic [19:0] fy;
    s = (cam_cfg.depth_scale == 0) ? 16'd1 : cam_cfg.depth_scale;
    fx = (cam_cfg.focal_x == 0) ? 20'd1 : cam_cfg.focal_x;
    fy = (cam_cfg.focal_y == 0) ? 20'd1 : cam_cfg.focal_y;
    // No measurement, nearer than half a metre, or beyond the far limit.
    if (px.depth == 0) return;
    if (2 * int'(px.depth) < int'(cam_cfg.depth_scale)) return;
    if (px.depth > cam_cfg.max_depth_code) return;
    pt.point_x = project_axis(px.col, cam_cfg.center_x, px.depth, s, fx);
    pt.point_y = project_axis(px.row, cam_cfg.center_y, px.depth, s, fy);
    pt.point_z = 32'((longint'(px.depth) << 16) / longint'(s));
    pt.out_blue = px.blue;
    pt.out_green = px.green;
    pt.out_red = px.red;
    pending_points.insert(pending_points.size(), pt);
  endfunction

  // Compare each delivered point against the oldest outstanding one.
  always @(posedge clk_i) begin
    dpb_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        $error("point delivered with none outstanding: %h", out_data_o);
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        if (out_data_o.point_x !== want.point_x) begin
          $error("point_x expected %h got %h", want.point_x, out_data_o.point_x);
          mismatches++;
        end
        if (out_data_o.point_y !== want.point_y) begin
          $error("point_y expected %h got %h", want.point_y, out_data_o.point_y);
          mismatches++;
        end
        if (out_data_o.point_z !== want.point_z) begin
          $error("point_z expected %h got %h", want.point_z, out_data_o.point_z);
          mismatches++;
        end
        if (out_data_o.out_blue !== want.out_blue) begin
          $error("out_blue expected %h got %h", want.out_blue, out_data_o.out_blue);
          mismatches++;
        end
        if (out_data_o.out_green !== want.out_green) begin
          $error("out_green expected %h got %h", want.out_green, out_data_o.out_green);
          mismatches++;
        end
        if (out_data_o.out_red !== want.out_red) begin
          $error("out_red expected %h got %h", want.out_red, out_data_o.out_red);
          mismatches++;
        end
      end
    end
  end

  // Drop the input valid, block until every outstanding point is back, then
  // let dropped pixels still in flight drain out of the pipeline.
  task automatic wait_idle();
    release_bus();
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Two-phase APB write; the shadow register updates at the access edge.
  task automatic write_reg(int unsigned idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'(idx * 4);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_DEPTH_SCALE: cam_cfg.depth_scale = value[15:0];
      REG_FOCAL_X:     cam_cfg.focal_x = value[19:0];
      REG_FOCAL_Y:     cam_cfg.focal_y = value[19:0];
      REG_CENTER_X:    cam_cfg.center_x = value[19:0];
      REG_CENTER_Y:    cam_cfg.center_y = value[19:0];
      REG_MAX_DEPTH:   cam_cfg.max_depth_code = value[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_camera(logic [15:0] s, logic [19:0] fx, logic [19:0] fy,
                             logic [19:0] cx, logic [19:0] cy, logic [15:0] maxd);
    wait_idle();
    write_reg(REG_DEPTH_SCALE, 32'(s));
    write_reg(REG_FOCAL_X, 32'(fx));
    write_reg(REG_FOCAL_Y, 32'(fy));
    write_reg(REG_CENTER_X, 32'(cx));
    write_reg(REG_CENTER_Y, 32'(cy));
    write_reg(REG_MAX_DEPTH, 32'(maxd));
  endtask

  // Offer one pixel, idling first at random; hold it until it transfers.
  task automatic send_pixel(dpb_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    project_pixel(px);
  endtask

  task automatic release_bus();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic dpb_in_t make_pixel(logic [11:0] c, logic [11:0] r, logic [15:0] d);
    dpb_in_t px;
    px.col = c;
    px.row = r;
    px.depth = d;
    px.blue = 8'($urandom);
    px.green = 8'($urandom);
    px.red = 8'($urandom);
    return px;
  endfunction

  // Mostly pixels that survive the range checks, some anywhere in range.
  function automatic dpb_in_t random_pixel();
    int unsigned lo;
    int unsigned hi;
    logic [15:0] d;
    lo = (int'(cam_cfg.depth_scale) + 1) / 2;
    if (lo == 0) lo = 1;
    hi = cam_cfg.max_depth_code;
    if ($urandom_range(99) < 80 && lo <= hi) d = 16'($urandom_range(hi, lo));
    else d = 16'($urandom);
    return make_pixel(12'($urandom), 12'($urandom), d);
  endfunction

  task automatic random_camera();
    logic [15:0] s;
    logic [19:0] fx;
    logic [19:0] fy;
    case ($urandom_range(3))
      0: s = 16'd1000;
      1: s = 16'($urandom_range(64, 1));
      2: s = 16'($urandom);
      default: s = 16'd65535;
    endcase
    fx = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(300000, 10000));
    fy = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(300000, 10000));
    load_camera(s, fx, fy, 20'($urandom), 20'($urandom),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF);
  endtask

  task automatic test_default_camera();
    send_pixel(make_pixel(12'd320, 12'd240, 16'd1000));
    send_pixel(make_pixel(12'd0, 12'd0, 16'd500));
    send_pixel(make_pixel(12'd4095, 12'd4095, 16'd65535));
    send_pixel(make_pixel(12'd639, 12'd479, 16'd2500));
  endtask

  // Each drop rule, right at and just past its threshold.
  task automatic test_drop_rules();
    load_camera(16'd1000, 20'd131072, 20'd131072, 20'd81920, 20'd61440, 16'd4000);
    send_pixel(make_pixel(12'd10, 12'd20, 16'd0));
    send_pixel(make_pixel(12'd10, 12'd20, 16'd499));
    send_pixel(make_pixel(12'd10, 12'd20, 16'd500));
    send_pixel(make_pixel(12'd10, 12'd20, 16'd4000));
    send_pixel(make_pixel(12'd10, 12'd20, 16'd4001));
    send_pixel(make_pixel(12'd10, 12'd20, 16'hFFFF));
    load_camera(16'd1000, 20'd131072, 20'd131072, 20'd81920, 20'd61440, 16'd0);
    send_pixel(make_pixel(12'd10, 12'd20, 16'd1));
    send_pixel(make_pixel(12'd10, 12'd20, 16'd800));
  endtask

  // Tiny scale and focal saturate x and y on both rails; then both at maximum.
  task automatic test_saturation();
    load_camera(16'd1, 20'd1, 20'd1, 20'hFFFFF, 20'd0, 16'hFFFF);
    send_pixel(make_pixel(12'd0, 12'd4095, 16'hFFFF));
    send_pixel(make_pixel(12'd4095, 12'd0, 16'd1));
    send_pixel(make_pixel(12'd4095, 12'd4095, 16'hFFFF));
    load_camera(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 20'd0, 20'hFFFFF, 16'hFFFF);
    send_pixel(make_pixel(12'd4095, 12'd0, 16'hFFFF));
    send_pixel(make_pixel(12'd0, 12'd4095, 16'd32768));
  endtask

  // Zero scale and focal registers act as one; writes past the map are ignored.
  task automatic test_zero_registers();
    load_camera(16'd0, 20'd0, 20'd0, 20'd1000, 20'd2000, 16'hFFFF);
    send_pixel(make_pixel(12'd3, 12'd700, 16'd1));
    send_pixel(make_pixel(12'd100, 12'd5, 16'd77));
    wait_idle();
    write_reg(BadRegIdx, 32'hFFFF_FFFF);
    write_reg(BadRegIdx + 1, 32'd0);
    send_pixel(make_pixel(12'd50, 12'd60, 16'd9));
  endtask

  task automatic test_random_traffic(int unsigned s_pct, int unsigned r_pct, int unsigned n);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 160 == 0) begin
        release_bus();
        random_camera();
      end
      send_pixel(random_pixel());
    end
    release_bus();
  endtask

  // Freeze the receiver while pixels keep coming so the pipe fills and
  // back-pressures the input, pause until it drains, then send 40 more.
  task automatic test_backpressure();
    load_camera(16'd1000, 20'd131072, 20'd131072, 20'd81920, 20'd61440, 16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk_i);
    hold_cycles = 400;
    for (int unsigned i = 0; i < 80; i++) send_pixel(random_pixel());
    release_bus();
    while (pending_points.size() != 0) @(posedge clk_i);
    for (int unsigned i = 0; i < 40; i++) send_pixel(random_pixel());
    release_bus();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    cam_cfg = '{depth_scale: 16'd1000, focal_x: 20'd131072, focal_y: 20'd131072,
                center_x: 20'd81920, center_y: 20'd61440, max_depth_code: 16'hFFFF};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_camera();
    test_drop_rules();
    test_saturation();
    test_zero_registers();
    test_backpressure();
    test_random_traffic(14, 87, 650);
    test_random_traffic(87, 14, 650);
    test_random_traffic(0, 0, 700);

    wait_idle();
    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
